/* hw/rtl/cad_pkg.sv */
// Package for the cartridge address decoder: target codes, register indexes,
// map type codes, the configuration struct and pipeline constants.
// No dependencies.
package cad_pkg;

    // widths of the configuration port and payload
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int ROM_SIZE_W  = 25;
    localparam int RAM_SIZE_W  = 18;
    localparam int OFFSET_W    = 24;
    localparam int TARGET_W    = 4;

    // default ROM index width and fold steps per pipeline stage
    localparam int ROM_INDEX_BITS_DEFAULT = 22;
    localparam int FOLD_STEPS             = 4;

    // a size above any 24-bit value, so that no fold step fires
    localparam logic [ROM_SIZE_W-1:0] SIZE_BYPASS = 25'h100_0000;

    // target codes
    localparam logic [TARGET_W-1:0] TGT_ROM         = 4'd0;
    localparam logic [TARGET_W-1:0] TGT_SRAM_RD     = 4'd1;
    localparam logic [TARGET_W-1:0] TGT_SRAM_WR     = 4'd2;
    localparam logic [TARGET_W-1:0] TGT_MMIO_RD     = 4'd3;
    localparam logic [TARGET_W-1:0] TGT_MMIO_WR     = 4'd4;
    localparam logic [TARGET_W-1:0] TGT_DSP_DATA_RD = 4'd5;
    localparam logic [TARGET_W-1:0] TGT_DSP_STAT_RD = 4'd6;
    localparam logic [TARGET_W-1:0] TGT_DSP_DATA_WR = 4'd7;
    localparam logic [TARGET_W-1:0] TGT_DECOMP_RD   = 4'd8;
    localparam logic [TARGET_W-1:0] TGT_BANKED_RD   = 4'd9;
    localparam logic [TARGET_W-1:0] TGT_OPEN_BUS    = 4'd10;
    localparam logic [TARGET_W-1:0] TGT_READ_ZERO   = 4'd11;
    localparam logic [TARGET_W-1:0] TGT_IGNORED     = 4'd12;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_TYPE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROM_SIZE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAM_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_MMIO    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_DSP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_DECOMP  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_BANKED  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SRAM_ENABLE = 3'd7;

    // map type codes
    localparam logic [1:0] MAP_LOROM = 2'd1;
    localparam logic [1:0] MAP_HIROM = 2'd2;

    // access kind
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [1:0]            map_type;
        logic [ROM_SIZE_W-1:0] rom_bytes;
        logic [RAM_SIZE_W-1:0] ram_size;
        logic                  has_mmio;
        logic                  has_dsp;
        logic                  has_decomp;
        logic                  has_banked;
        logic                  sram_enable;
    } cad_cfg_t;

endpackage

/* hw/rtl/cartridge_address_decoder.sv */
// Cartridge address decoder top level: configuration registers, decode stage,
// ROM fold pipeline and output register. Depends on cad_pkg, cad_decode and
// cad_fold_stage.
//
// Every bus access goes through a fixed pipeline of 2 + ceil(ROM_INDEX_BITS/4)
// register stages from input transfer to result, and a new access may enter
// every cycle while the output is not held back. The depth is set by the ROM
// top-bit fold, which covers up to four address bits per stage; all accesses
// take the same path, so results leave in order. Each stage holds its item
// while the next one is full, so back-pressure on the output stops the
// pipeline without loss. Configuration writes take effect at once and are
// meant for times when no access is in flight.
module cartridge_address_decoder import cad_pkg::*;
#(
    parameter int ROM_INDEX_BITS = ROM_INDEX_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic [7:0]             bank,
    input  logic [15:0]            address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TARGET_W-1:0]    target,
    output logic [OFFSET_W-1:0]    offset
);

    localparam int NUM_FOLD = (ROM_INDEX_BITS + FOLD_STEPS - 1) / FOLD_STEPS;

    cad_cfg_t cfg_reg;

    logic [TARGET_W-1:0]   dec_target;
    logic [OFFSET_W-1:0]   dec_value;
    logic [ROM_SIZE_W-1:0] dec_size;

    // pipeline links; index 0 is the decode register
    logic [NUM_FOLD:0]         link_valid;
    logic [NUM_FOLD:0]         link_ready;
    logic [TARGET_W-1:0]       link_target [NUM_FOLD:0];
    logic [OFFSET_W-1:0]       link_value  [NUM_FOLD:0];
    logic [ROM_SIZE_W-1:0]     link_size   [NUM_FOLD:0];
    logic [ROM_INDEX_BITS-1:0] link_base   [NUM_FOLD:0];

    logic                  s0_valid_reg;
    logic [TARGET_W-1:0]   s0_target_reg;
    logic [OFFSET_W-1:0]   s0_value_reg;
    logic [ROM_SIZE_W-1:0] s0_size_reg;

    logic                  out_valid_reg;
    logic [TARGET_W-1:0]   target_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic                  out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAP_TYPE:    cfg_reg.map_type    <= cfg_data[1:0];
                REG_ROM_SIZE:    cfg_reg.rom_bytes   <= cfg_data[ROM_SIZE_W-1:0];
                REG_RAM_SIZE:    cfg_reg.ram_size    <= cfg_data[RAM_SIZE_W-1:0];
                REG_HAS_MMIO:    cfg_reg.has_mmio    <= cfg_data[0];
                REG_HAS_DSP:     cfg_reg.has_dsp     <= cfg_data[0];
                REG_HAS_DECOMP:  cfg_reg.has_decomp  <= cfg_data[0];
                REG_HAS_BANKED:  cfg_reg.has_banked  <= cfg_data[0];
                REG_SRAM_ENABLE: cfg_reg.sram_enable <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // window decode
    cad_decode #(
        .ROM_INDEX_BITS (ROM_INDEX_BITS)
    ) u_decode (
        .cfg     (cfg_reg),
        .op      (op),
        .bank    (bank),
        .address (address),
        .target  (dec_target),
        .value   (dec_value),
        .size    (dec_size)
    );

    // decode stage register
    assign in_ready = !s0_valid_reg || link_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (in_ready)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s0_target_reg <= dec_target;
            s0_value_reg  <= dec_value;
            s0_size_reg   <= dec_size;
        end
    end

    assign link_valid[0]  = s0_valid_reg;
    assign link_target[0] = s0_target_reg;
    assign link_value[0]  = s0_value_reg;
    assign link_size[0]   = s0_size_reg;
    assign link_base[0]   = '0;

    // rom fold stages
    for (genvar g = 0; g < NUM_FOLD; g++)
    begin : g_fold
        cad_fold_stage #(
            .ROM_INDEX_BITS (ROM_INDEX_BITS),
            .FIRST_BIT      (ROM_INDEX_BITS - 1 - g * FOLD_STEPS)
        ) u_fold (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (link_valid[g]),
            .in_ready   (link_ready[g]),
            .in_target  (link_target[g]),
            .in_value   (link_value[g]),
            .in_size    (link_size[g]),
            .in_base    (link_base[g]),
            .out_valid  (link_valid[g+1]),
            .out_ready  (link_ready[g+1]),
            .out_target (link_target[g+1]),
            .out_value  (link_value[g+1]),
            .out_size   (link_size[g+1]),
            .out_base   (link_base[g+1])
        );
    end

    // output register: chunk base plus folded address
    assign out_load             = !out_valid_reg || out_ready;
    assign link_ready[NUM_FOLD] = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= link_valid[NUM_FOLD];
    end

    always_ff @(posedge clk)
    begin
        if (out_load && link_valid[NUM_FOLD])
        begin
            target_reg <= link_target[NUM_FOLD];
            offset_reg <= link_value[NUM_FOLD]
                          + OFFSET_W'(link_base[NUM_FOLD]);
        end
    end

    assign out_valid = out_valid_reg;
    assign target    = target_reg;
    assign offset    = offset_reg;

    // size is only consumed inside the fold stages
    logic unused_size;
    assign unused_size = ^link_size[NUM_FOLD];

endmodule

/* hw/rtl/cad_decode.sv */
// Window decode of one bus access: target code, offset or raw ROM address,
// and the size that drives the ROM fold stages. Depends on cad_pkg.
module cad_decode import cad_pkg::*;
#(
    parameter int ROM_INDEX_BITS = ROM_INDEX_BITS_DEFAULT
)
(
    input  cad_cfg_t              cfg,
    input  logic                  op,
    input  logic [7:0]            bank,
    input  logic [15:0]           address,
    output logic [TARGET_W-1:0]   target,
    output logic [OFFSET_W-1:0]   value,
    output logic [ROM_SIZE_W-1:0] size
);

    localparam logic [OFFSET_W-1:0] ROM_MASK =
        OFFSET_W'((25'(1) << ROM_INDEX_BITS) - 25'(1));

    logic                  wr;
    logic [6:0]            b;
    logic                  win67;
    logic                  ram_nz;
    logic [RAM_SIZE_W:0]   ram_mask;
    logic [OFFSET_W-1:0]   full;
    logic [OFFSET_W-1:0]   rom_raw;
    logic [OFFSET_W-1:0]   rom_a;
    logic [ROM_SIZE_W-1:0] rom_size_m1;
    logic                  rom_pow2;
    logic [RAM_SIZE_W:0]   sram_lo;
    logic [RAM_SIZE_W:0]   sram_hi_mmio;
    logic [RAM_SIZE_W:0]   sram_hi;
    logic                  is_rom;
    logic [RAM_SIZE_W:0]   sram_sel;
    logic                  is_sram;
    logic [OFFSET_W-1:0]   win_value;

    // common window terms
    assign wr          = (op == OP_WRITE);
    assign b           = bank[6:0];
    assign win67       = (address[15:13] == 3'b011);
    assign ram_nz      = (cfg.ram_size != '0);
    assign ram_mask    = {1'b0, cfg.ram_size - RAM_SIZE_W'(1)};
    assign full        = {bank, address};
    assign rom_size_m1 = cfg.rom_bytes - ROM_SIZE_W'(1);
    assign rom_pow2    = ((cfg.rom_bytes & rom_size_m1) == '0);

    // sram index candidates before the size mask
    assign sram_lo      = {bank[3:0], address[14:0]};
    assign sram_hi_mmio = {1'b0, b[2:0], address[14:0]};
    assign sram_hi      = {b[5:0], address[12:0]};

    // window select
    always_comb
    begin
        target    = wr ? TGT_IGNORED : TGT_OPEN_BUS;
        win_value = '0;
        is_rom    = 1'b0;
        is_sram   = 1'b0;
        sram_sel  = '0;
        rom_raw   = '0;
        if (cfg.map_type == MAP_LOROM)
        begin
            if (!wr && cfg.has_decomp && bank >= 8'hc0)
            begin
                target    = TGT_DECOMP_RD;
                win_value = full;
            end
            else if (((bank >= 8'h70 && bank < 8'h7e) || bank >= 8'hf0)
                     && !address[15] && ram_nz)
            begin
                target   = wr ? TGT_SRAM_WR : TGT_SRAM_RD;
                is_sram  = 1'b1;
                sram_sel = sram_lo;
            end
            else if (cfg.has_mmio && b < 7'h40 && win67)
            begin
                target    = wr ? TGT_MMIO_WR : TGT_MMIO_RD;
                win_value = {8'h00, address};
            end
            else if (cfg.has_dsp && b >= 7'h30 && b < 7'h40 && address[15])
            begin
                if (wr)
                    target = (address < 16'hc000) ? TGT_DSP_DATA_WR : TGT_IGNORED;
                else
                    target = (address < 16'hc000) ? TGT_DSP_DATA_RD : TGT_DSP_STAT_RD;
            end
            else if (wr)
            begin
                target = TGT_IGNORED;
            end
            else if (address[15] || b >= 7'h40)
            begin
                target  = TGT_ROM;
                is_rom  = 1'b1;
                rom_raw = {2'b00, b, address[14:0]};
            end
            else
            begin
                target = TGT_OPEN_BUS;
            end
        end
        else if (cfg.map_type == MAP_HIROM)
        begin
            if (!wr && cfg.has_banked
                && (bank == 8'h50 || (bank >= 8'h40 && bank <= 8'h4f) || bank >= 8'hc0))
            begin
                target    = TGT_BANKED_RD;
                win_value = full;
            end
            else if (!wr && cfg.has_banked && b >= 7'h10 && b < 7'h40 && address[15])
            begin
                target = TGT_OPEN_BUS;
            end
            else if (!wr && cfg.has_decomp && bank[7:6] == 2'b11)
            begin
                target    = TGT_DECOMP_RD;
                win_value = full;
            end
            else if (cfg.has_mmio && b < 7'h40 && win67)
            begin
                target    = wr ? TGT_MMIO_WR : TGT_MMIO_RD;
                win_value = {8'h00, address};
            end
            else if (cfg.has_mmio && ram_nz && b >= 7'h70 && b < 7'h78 && !address[15])
            begin
                target   = wr ? TGT_SRAM_WR : TGT_SRAM_RD;
                is_sram  = 1'b1;
                sram_sel = sram_hi_mmio;
            end
            else if (cfg.has_dsp && b < 7'h20 && win67)
            begin
                if (wr)
                    target = (address < 16'h7000) ? TGT_DSP_DATA_WR : TGT_IGNORED;
                else
                    target = (address < 16'h7000) ? TGT_DSP_DATA_RD : TGT_DSP_STAT_RD;
            end
            else if (b < 7'h40 && win67 && ram_nz)
            begin
                if (cfg.has_banked && !cfg.sram_enable)
                begin
                    target = wr ? TGT_IGNORED : TGT_READ_ZERO;
                end
                else
                begin
                    target   = wr ? TGT_SRAM_WR : TGT_SRAM_RD;
                    is_sram  = 1'b1;
                    sram_sel = sram_hi;
                end
            end
            else if (wr)
            begin
                target = TGT_IGNORED;
            end
            else if (address[15] || b >= 7'h40)
            begin
                target  = TGT_ROM;
                is_rom  = 1'b1;
                rom_raw = {2'b00, b[5:0], address};
            end
            else
            begin
                target = TGT_OPEN_BUS;
            end
        end
        if (is_sram)
            win_value = {{(OFFSET_W-RAM_SIZE_W-1){1'b0}}, sram_sel & ram_mask};
    end

    // rom mirroring setup: zero and power-of-two sizes finish here
    assign rom_a = rom_raw & ROM_MASK;

    always_comb
    begin
        size  = SIZE_BYPASS;
        value = win_value;
        if (is_rom)
        begin
            if (cfg.rom_bytes == '0)
                value = '0;
            else if (rom_pow2)
                value = rom_a & rom_size_m1[OFFSET_W-1:0];
            else
            begin
                value = rom_a;
                size  = cfg.rom_bytes;
            end
        end
    end

endmodule

/* hw/rtl/cad_fold_stage.sv */
// One register stage of the ROM top-bit fold, covering up to FOLD_STEPS
// address bits from FIRST_BIT downward. Depends on cad_pkg.
module cad_fold_stage import cad_pkg::*;
#(
    parameter int ROM_INDEX_BITS = ROM_INDEX_BITS_DEFAULT,
    parameter int FIRST_BIT      = ROM_INDEX_BITS_DEFAULT - 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [TARGET_W-1:0]       in_target,
    input  logic [OFFSET_W-1:0]       in_value,
    input  logic [ROM_SIZE_W-1:0]     in_size,
    input  logic [ROM_INDEX_BITS-1:0] in_base,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [TARGET_W-1:0]       out_target,
    output logic [OFFSET_W-1:0]       out_value,
    output logic [ROM_SIZE_W-1:0]     out_size,
    output logic [ROM_INDEX_BITS-1:0] out_base
);

    localparam int STEPS = (FIRST_BIT + 1 < FOLD_STEPS) ? FIRST_BIT + 1 : FOLD_STEPS;

    logic                      valid_reg;
    logic [TARGET_W-1:0]       target_reg;
    logic [OFFSET_W-1:0]       value_reg;
    logic [ROM_SIZE_W-1:0]     size_reg;
    logic [ROM_INDEX_BITS-1:0] base_reg;
    logic [OFFSET_W-1:0]       value_next;
    logic [ROM_SIZE_W-1:0]     size_next;
    logic [ROM_INDEX_BITS-1:0] base_next;
    logic [ROM_SIZE_W-1:0]     step_bit;

    // fold steps: drop the top set bit while the address is past the size
    always_comb
    begin
        value_next = in_value;
        size_next  = in_size;
        base_next  = in_base;
        step_bit   = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            step_bit = ROM_SIZE_W'(1) << (FIRST_BIT - k);
            if ({1'b0, value_next} >= size_next && value_next[FIRST_BIT - k])
            begin
                value_next[FIRST_BIT - k] = 1'b0;
                if (size_next > step_bit)
                begin
                    size_next = size_next - step_bit;
                    base_next = base_next + step_bit[ROM_INDEX_BITS-1:0];
                end
            end
        end
    end

    // stage handshake
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            target_reg <= in_target;
            value_reg  <= value_next;
            size_reg   <= size_next;
            base_reg   <= base_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_target = target_reg;
    assign out_value  = value_reg;
    assign out_size   = size_reg;
    assign out_base   = base_reg;

endmodule
